// ----- sv/audio_front_end_hpf_preemph_agc_macros.svh -----
// Assertion macros shared by the audio front end RTL.
`ifndef AUDIO_FRONT_END_HPF_PREEMPH_AGC_MACROS_SVH
`define AUDIO_FRONT_END_HPF_PREEMPH_AGC_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AFE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define AFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/afe_pkg.sv -----
// Shared constants and types of the audio front end.
`default_nettype none

package afe_pkg;

   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam int COEF_W     = 15;
   localparam int KCOEF_W    = 16;
   localparam int ENV_W      = 24;
   localparam int TARGET_W   = 15;
   localparam int FLOOR_W    = 15;
   localparam int GAIN_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Serial multiplier takes one multiplier bit per cycle over a fixed word.
   localparam int MUL_BITS     = 24;
   localparam int TARGET_SHIFT = 18;
   localparam int DIV_BITS     = TARGET_W + TARGET_SHIFT;
   localparam int CNT_W        = 6;
   localparam int FLOOR_SHIFT  = 8;
   localparam int COEF_SHIFT   = 15;
   localparam int GAIN_SHIFT   = 10;

   localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd1024;

   localparam logic [COEF_W-1:0]   HPF_COEF_RST     = 15'd32767;
   localparam logic [KCOEF_W-1:0]  PREEMPH_COEF_RST = 16'd0;
   localparam logic [ENV_W-1:0]    AGC_RELEASE_RST  = 24'd16777041;
   localparam logic [TARGET_W-1:0] AGC_TARGET_RST   = 15'd22938;
   localparam logic [GAIN_W-1:0]   AGC_MAX_GAIN_RST = 16'd40960;
   localparam logic [FLOOR_W-1:0]  AGC_FLOOR_RST    = 15'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HPF_ENABLE   = 3'd0,
      CSR_HPF_COEF     = 3'd1,
      CSR_PREEMPH_COEF = 3'd2,
      CSR_AGC_ENABLE   = 3'd3,
      CSR_AGC_RELEASE  = 3'd4,
      CSR_AGC_TARGET   = 3'd5,
      CSR_AGC_MAX_GAIN = 3'd6,
      CSR_AGC_FLOOR    = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

// ----- sv/afe_channels.sv -----
// Valid/ready channel interfaces for the sample and result streams.
`default_nettype none

interface afe_req_if #(
   parameter int SAMPLE_WIDTH = afe_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;
   logic                           utterance_start;
   logic                           env_clear;

   modport source (output valid, output sample_in, output utterance_start,
                   output env_clear, input ready);
   modport sink   (input valid, input sample_in, input utterance_start,
                   input env_clear, output ready);
endinterface

interface afe_rsp_if #(
   parameter int SAMPLE_WIDTH = afe_pkg::SAMPLE_WIDTH_DEF
);
   logic                             valid;
   logic                             ready;
   logic signed [SAMPLE_WIDTH-1:0]   sample_out;
   logic [afe_pkg::GAIN_W-1:0]       gain_applied;
   logic                             saturated;

   modport source (output valid, output sample_out, output gain_applied,
                   output saturated, input ready);
   modport sink   (input valid, input sample_out, input gain_applied,
                   input saturated, output ready);
endinterface

`default_nettype wire

// ----- sv/audio_front_end_hpf_preemph_agc.sv -----
// Audio front end: one-pole high-pass, pre-emphasis and peak AGC, bit-serial datapath.
//
//   channel   dir   handshake              payload
//   req_if    in    valid/ready            sample_in, utterance_start, env_clear
//   rsp_if    out   valid/ready            sample_out, gain_applied, saturated
//   csr_*     in    csr_write_en only      csr_index, csr_wdata
//
// Each product runs through the shared shift-add multiplier at one bit per cycle,
// and the AGC gain runs through a restoring divider at one quotient bit per cycle.
// The high-pass adds a product; the AGC adds a decay product when the envelope
// does not rise and a divide when it is above the floor.
// Reset is synchronous; it clears the filter history and the envelope and resets config.
// A finished result waits in the output register while the next beat is taken;
// the engine only stalls if a second result is ready before the first is taken.
`default_nettype none
`include "audio_front_end_hpf_preemph_agc_macros.svh"

module audio_front_end_hpf_preemph_agc #(
   parameter int SAMPLE_WIDTH = afe_pkg::SAMPLE_WIDTH_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   afe_req_if.sink                                 req_if,
   afe_rsp_if.source                               rsp_if,
   input  wire logic                               csr_write_en,
   input  wire logic [afe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [afe_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import afe_pkg::*;

   localparam int SW      = SAMPLE_WIDTH;
   localparam int WIDE_W  = SW + 2;
   localparam int MC_W    = (SW + 3 > ENV_W + 1) ? SW + 3 : ENV_W + 1;
   localparam int ACC_W   = MC_W + 1;
   localparam int PROD_W  = ACC_W + MUL_BITS;
   localparam int RND_W   = PROD_W + 1;
   localparam int SH15_W  = RND_W - COEF_SHIFT;
   localparam int DIFF_W  = SH15_W + 1;
   localparam int SH10_W  = RND_W - GAIN_SHIFT;
   localparam int MAG_W   = ENV_W + 2;
   localparam int MAG_SHL = ENV_W - SW;

   localparam logic [RND_W-1:0] RND15 = RND_W'(1) << (COEF_SHIFT - 1);
   localparam logic [RND_W-1:0] RND10 = RND_W'(1) << (GAIN_SHIFT - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_HPF_MUL, ST_HPF_END, ST_PRE_MUL, ST_PRE_END,
      ST_ENV, ST_DECAY_MUL, ST_DECAY_END, ST_GAIN, ST_DIV, ST_DIV_END,
      ST_OUT_MUL, ST_PUSH
   } state_type;

   // Configuration registers
   logic                       hpf_enable_ff;
   logic [COEF_W-1:0]          hpf_coef_ff;
   logic signed [KCOEF_W-1:0]  preemph_coef_ff;
   logic                       agc_enable_ff;
   logic [ENV_W-1:0]           agc_release_ff;
   logic [TARGET_W-1:0]        agc_target_ff;
   logic [GAIN_W-1:0]          agc_max_gain_ff;
   logic [FLOOR_W-1:0]         agc_floor_ff;

   // Control, history and working registers
   state_type                  state_ff;
   logic signed [SW-1:0]       x_ff;
   logic signed [SW-1:0]       hpf_xprev_ff;
   logic signed [WIDE_W-1:0]   hpf_yprev_ff;
   logic signed [WIDE_W-1:0]   pre_xprev_ff;
   logic [ENV_W-1:0]           env_ff;
   logic signed [WIDE_W-1:0]   v_ff;
   logic signed [WIDE_W-1:0]   p_ff;
   logic [GAIN_W-1:0]          gain_ff;
   logic                       sat_ff;
   logic [CNT_W-1:0]           cnt_ff;

   // Serial multiplier and divider
   logic signed [MC_W-1:0]     mcand_ff;
   logic signed [ACC_W-1:0]    mul_hi_ff, mul_hi_in;
   logic [MUL_BITS-1:0]        mul_lo_ff, mul_lo_in;
   logic                       mul_sgn_ff;
   logic [ENV_W-1:0]           div_rem_ff, div_rem_in;
   logic [DIV_BITS-1:0]        div_quo_ff, div_quo_in;

   // Output register
   logic                       rsp_valid_ff;
   logic signed [SW-1:0]       rsp_sample_ff;
   logic [GAIN_W-1:0]          rsp_gain_ff;
   logic                       rsp_sat_ff;

   // Datapath helpers
   logic signed [ACC_W-1:0]    mul_addend, mul_sum;
   logic                       mul_last, div_last;
   logic signed [PROD_W-1:0]   prod;
   logic [RND_W-1:0]           prod_rnd15, prod_rnd10;
   logic signed [SH15_W-1:0]   sh15;
   logic signed [SH10_W-1:0]   sh10;
   logic signed [DIFF_W-1:0]   pre_diff;
   logic [WIDE_W:0]            hpf_clip, pre_clip;
   logic [SW:0]                out_clip;
   logic signed [MC_W-1:0]     hpf_s;
   logic [WIDE_W-1:0]          p_abs;
   logic [MAG_W-1:0]           mag_w;
   logic                       mag_sat;
   logic [ENV_W-1:0]           env_mag;
   logic [ENV_W+1:0]           div_diff;
   logic                       div_ge;
   logic                       div_over;
   logic [GAIN_W-1:0]          div_gain;
   logic                       rsp_free;

   function automatic logic [WIDE_W:0] clip_wide(input logic signed [DIFF_W-1:0] v);
      logic all_zero, all_one;
      all_zero = ~|v[DIFF_W-1:WIDE_W-1];
      all_one  = &v[DIFF_W-1:WIDE_W-1];
      if (all_zero || all_one) begin
         return {1'b0, v[WIDE_W-1:0]};
      end else if (v[DIFF_W-1]) begin
         return {1'b1, 1'b1, {(WIDE_W-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(WIDE_W-1){1'b1}}};
      end
   endfunction

   function automatic logic [SW:0] clip_out(input logic signed [SH10_W-1:0] v);
      logic all_zero, all_one;
      all_zero = ~|v[SH10_W-1:SW-1];
      all_one  = &v[SH10_W-1:SW-1];
      if (all_zero || all_one) begin
         return {1'b0, v[SW-1:0]};
      end else if (v[SH10_W-1]) begin
         return {1'b1, 1'b1, {(SW-1){1'b0}}};
      end else begin
         return {1'b1, 1'b0, {(SW-1){1'b1}}};
      end
   endfunction

   // Shift-add step: add on a set multiplier bit, subtract on the sign bit of a signed multiplier.
   always_comb begin
      mul_last   = (cnt_ff == CNT_W'(MUL_BITS - 1));
      mul_addend = mul_lo_ff[0] ? ACC_W'(mcand_ff) : '0;
      mul_sum    = (mul_sgn_ff && mul_last) ? mul_hi_ff - mul_addend
                                            : mul_hi_ff + mul_addend;
      mul_hi_in  = {mul_sum[ACC_W-1], mul_sum[ACC_W-1:1]};
      mul_lo_in  = {mul_sum[0], mul_lo_ff[MUL_BITS-1:1]};
   end

   // Restoring divide step: one quotient bit per cycle.
   always_comb begin
      div_last   = (cnt_ff == CNT_W'(DIV_BITS - 1));
      div_diff   = {1'b0, div_rem_ff, div_quo_ff[DIV_BITS-1]} - {2'b00, env_ff};
      div_ge     = ~div_diff[ENV_W+1];
      div_rem_in = div_ge ? div_diff[ENV_W-1:0]
                          : {div_rem_ff[ENV_W-2:0], div_quo_ff[DIV_BITS-1]};
      div_quo_in = {div_quo_ff[DIV_BITS-2:0], div_ge};
      div_over   = (|div_quo_ff[DIV_BITS-1:GAIN_W]) ||
                   (div_quo_ff[GAIN_W-1:0] > agc_max_gain_ff);
      div_gain   = div_over ? agc_max_gain_ff : div_quo_ff[GAIN_W-1:0];
   end

   always_comb begin
      prod       = {mul_hi_ff, mul_lo_ff};
      prod_rnd15 = RND_W'(prod) + RND15;
      prod_rnd10 = RND_W'(prod) + RND10;
      sh15       = prod_rnd15[RND_W-1:COEF_SHIFT];
      sh10       = prod_rnd10[RND_W-1:GAIN_SHIFT];
      hpf_clip   = clip_wide(DIFF_W'(sh15));
      pre_diff   = DIFF_W'(v_ff) - DIFF_W'(sh15);
      pre_clip   = clip_wide(pre_diff);
      out_clip   = clip_out(sh10);
      hpf_s      = MC_W'(hpf_yprev_ff) + MC_W'(x_ff) - MC_W'(hpf_xprev_ff);
      p_abs      = p_ff[WIDE_W-1] ? (~p_ff + 1'b1) : p_ff;
      mag_w      = MAG_W'(p_abs) << MAG_SHL;
      mag_sat    = |mag_w[MAG_W-1:ENV_W];
      env_mag    = mag_sat ? '1 : mag_w[ENV_W-1:0];
      rsp_free   = !rsp_valid_ff || rsp_if.ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hpf_enable_ff   <= 1'b0;
         hpf_coef_ff     <= HPF_COEF_RST;
         preemph_coef_ff <= PREEMPH_COEF_RST;
         agc_enable_ff   <= 1'b0;
         agc_release_ff  <= AGC_RELEASE_RST;
         agc_target_ff   <= AGC_TARGET_RST;
         agc_max_gain_ff <= AGC_MAX_GAIN_RST;
         agc_floor_ff    <= AGC_FLOOR_RST;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_HPF_ENABLE:   hpf_enable_ff   <= csr_wdata[0];
            CSR_HPF_COEF:     hpf_coef_ff     <= csr_wdata[COEF_W-1:0];
            CSR_PREEMPH_COEF: preemph_coef_ff <= csr_wdata[KCOEF_W-1:0];
            CSR_AGC_ENABLE:   agc_enable_ff   <= csr_wdata[0];
            CSR_AGC_RELEASE:  agc_release_ff  <= csr_wdata[ENV_W-1:0];
            CSR_AGC_TARGET:   agc_target_ff   <= csr_wdata[TARGET_W-1:0];
            CSR_AGC_MAX_GAIN: agc_max_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_AGC_FLOOR:    agc_floor_ff    <= csr_wdata[FLOOR_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hpf_xprev_ff <= '0;
         hpf_yprev_ff <= '0;
         pre_xprev_ff <= '0;
         env_ff       <= '0;
      end else begin
         if (state_ff == ST_PUSH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  x_ff    <= req_if.sample_in;
                  sat_ff  <= 1'b0;
                  gain_ff <= UNITY_GAIN;
                  if (req_if.utterance_start) begin
                     hpf_xprev_ff <= '0;
                     hpf_yprev_ff <= '0;
                     pre_xprev_ff <= '0;
                  end
                  if (req_if.env_clear) begin
                     env_ff <= '0;
                  end
                  state_ff <= ST_START;
               end
            end
            ST_START: begin
               cnt_ff    <= '0;
               mul_hi_ff <= '0;
               if (hpf_enable_ff) begin
                  mcand_ff   <= hpf_s;
                  mul_lo_ff  <= MUL_BITS'(hpf_coef_ff);
                  mul_sgn_ff <= 1'b0;
                  state_ff   <= ST_HPF_MUL;
               end else begin
                  v_ff       <= WIDE_W'(x_ff);
                  mcand_ff   <= MC_W'(pre_xprev_ff);
                  mul_lo_ff  <= MUL_BITS'(preemph_coef_ff);
                  mul_sgn_ff <= 1'b1;
                  state_ff   <= ST_PRE_MUL;
               end
            end
            ST_HPF_MUL, ST_PRE_MUL, ST_DECAY_MUL, ST_OUT_MUL: begin
               mul_hi_ff <= mul_hi_in;
               mul_lo_ff <= mul_lo_in;
               cnt_ff    <= cnt_ff + 1'b1;
               if (mul_last) begin
                  unique case (state_ff)
                     ST_HPF_MUL:   state_ff <= ST_HPF_END;
                     ST_PRE_MUL:   state_ff <= ST_PRE_END;
                     ST_DECAY_MUL: state_ff <= ST_DECAY_END;
                     default:      state_ff <= ST_PUSH;
                  endcase
               end
            end
            ST_HPF_END: begin
               hpf_yprev_ff <= hpf_clip[WIDE_W-1:0];
               hpf_xprev_ff <= x_ff;
               v_ff         <= hpf_clip[WIDE_W-1:0];
               sat_ff       <= sat_ff | hpf_clip[WIDE_W];
               cnt_ff       <= '0;
               mul_hi_ff    <= '0;
               mcand_ff     <= MC_W'(pre_xprev_ff);
               mul_lo_ff    <= MUL_BITS'(preemph_coef_ff);
               mul_sgn_ff   <= 1'b1;
               state_ff     <= ST_PRE_MUL;
            end
            ST_PRE_END: begin
               p_ff         <= pre_clip[WIDE_W-1:0];
               pre_xprev_ff <= v_ff;
               sat_ff       <= sat_ff | pre_clip[WIDE_W];
               if (agc_enable_ff) begin
                  state_ff <= ST_ENV;
               end else begin
                  // Unity gain still goes through the output product.
                  cnt_ff     <= '0;
                  mul_hi_ff  <= '0;
                  mcand_ff   <= MC_W'($signed(pre_clip[WIDE_W-1:0]));
                  mul_lo_ff  <= MUL_BITS'(UNITY_GAIN);
                  mul_sgn_ff <= 1'b0;
                  state_ff   <= ST_OUT_MUL;
               end
            end
            ST_ENV: begin
               sat_ff <= sat_ff | mag_sat;
               if (env_mag > env_ff) begin
                  env_ff   <= env_mag;
                  state_ff <= ST_GAIN;
               end else begin
                  cnt_ff     <= '0;
                  mul_hi_ff  <= '0;
                  mcand_ff   <= MC_W'(env_ff);
                  mul_lo_ff  <= agc_release_ff;
                  mul_sgn_ff <= 1'b0;
                  state_ff   <= ST_DECAY_MUL;
               end
            end
            ST_DECAY_END: begin
               env_ff   <= prod[2*ENV_W-1:ENV_W];
               state_ff <= ST_GAIN;
            end
            ST_GAIN: begin
               cnt_ff <= '0;
               if (env_ff <= (ENV_W'(agc_floor_ff) << FLOOR_SHIFT)) begin
                  gain_ff    <= agc_max_gain_ff;
                  mul_hi_ff  <= '0;
                  mcand_ff   <= MC_W'(p_ff);
                  mul_lo_ff  <= MUL_BITS'(agc_max_gain_ff);
                  mul_sgn_ff <= 1'b0;
                  state_ff   <= ST_OUT_MUL;
               end else begin
                  div_rem_ff <= '0;
                  div_quo_ff <= DIV_BITS'(agc_target_ff) << TARGET_SHIFT;
                  state_ff   <= ST_DIV;
               end
            end
            ST_DIV: begin
               div_rem_ff <= div_rem_in;
               div_quo_ff <= div_quo_in;
               cnt_ff     <= cnt_ff + 1'b1;
               if (div_last) begin
                  state_ff <= ST_DIV_END;
               end
            end
            ST_DIV_END: begin
               gain_ff    <= div_gain;
               cnt_ff     <= '0;
               mul_hi_ff  <= '0;
               mcand_ff   <= MC_W'(p_ff);
               mul_lo_ff  <= MUL_BITS'(div_gain);
               mul_sgn_ff <= 1'b0;
               state_ff   <= ST_OUT_MUL;
            end
            ST_PUSH: begin
               // Hold here until the output register frees up.
               if (rsp_free) begin
                  rsp_sample_ff <= out_clip[SW-1:0];
                  rsp_sat_ff    <= sat_ff | out_clip[SW];
                  rsp_gain_ff   <= gain_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sample_out   = rsp_sample_ff;
   assign rsp_if.gain_applied = rsp_gain_ff;
   assign rsp_if.saturated    = rsp_sat_ff;

   `AFE_ASSERT_NEXT(a_accept_starts_work, clock, reset, req_if.valid && req_if.ready, state_ff == ST_START, "accepted beat did not start the engine")
   `AFE_ASSERT_IMPLY(a_div_above_floor, clock, reset, state_ff == ST_DIV, env_ff > (ENV_W'(agc_floor_ff) << FLOOR_SHIFT), "divide entered with envelope at or below floor")
   `AFE_ASSERT_NEXT(a_unity_gain_when_off, clock, reset, state_ff == ST_PUSH && rsp_free && !agc_enable_ff, rsp_gain_ff == UNITY_GAIN, "gain not unity with AGC off")
   `AFE_ASSERT_IMPLY(a_mul_count_bound, clock, reset, state_ff == ST_HPF_MUL || state_ff == ST_PRE_MUL || state_ff == ST_DECAY_MUL || state_ff == ST_OUT_MUL, cnt_ff < CNT_W'(MUL_BITS), "multiplier ran past its last bit")

endmodule

`default_nettype wire
